>>> src/sdnc_pkg.sv
// ----------------------------------------------------------------------------
// sdnc_pkg
// Shared types and constants for the scoped duplicate number checker:
// request and result payloads, command codes and status codes.
// ----------------------------------------------------------------------------
package sdnc_pkg;

  // width of one stored number
  localparam int NUMBER_WIDTH = 16;

  // default number of entries in the number store
  localparam int STORE_DEPTH_DEFAULT = 1024;

  // scope hierarchy: zone, net, node, point
  localparam int LEVEL_COUNT = 4;
  localparam int LEVEL_WIDTH = $clog2(LEVEL_COUNT);

  // node level after reset
  localparam logic [LEVEL_WIDTH-1:0] NODE_LEVEL_RESET = LEVEL_WIDTH'(2);

  // request commands
  typedef enum logic {
    CMD_ADD     = 1'b0,
    CMD_RESTORE = 1'b1
  } command_t;

  // duplicate status codes
  localparam logic [1:0] STATUS_UNIQUE = 2'd0;
  localparam logic [1:0] STATUS_LOW    = 2'd1;
  localparam logic [1:0] STATUS_HIGH   = 2'd2;

  typedef logic [LEVEL_WIDTH-1:0] level_t;

  // request payload
  typedef struct packed {
    command_t                command;
    level_t                  scope_level;
    logic [NUMBER_WIDTH-1:0] number;
    logic                    mark;
  } req_t;

  // result payload
  typedef struct packed {
    logic [1:0] duplicate_status;
    logic       store_full;
  } res_t;

endpackage

>>> src/sdnc_ram.sv
// ----------------------------------------------------------------------------
// sdnc_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module sdnc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

>>> src/scoped_duplicate_number_checker.sv
// ----------------------------------------------------------------------------
// scoped_duplicate_number_checker
// Stack of numbers in nested zone/net/node/point scopes with duplicate
// detection inside the current scope.
// ----------------------------------------------------------------------------
// An add request first moves the current scope to the requested level, then
// scans the current scope one stored number per cycle through the store RAM
// read port, stopping at the first match, then appends the number (or flags
// the store full); a restore request skips the scan and goes to the result.
// The block takes one request at a time: req_ready is high only while idle,
// and a finished result waits in ST_DONE until the output register is free,
// so a result not yet taken holds up the next request.
// node_level may be written at any time the block is idle.
// ----------------------------------------------------------------------------
module scoped_duplicate_number_checker
  import sdnc_pkg::*;
#(
  parameter int STORE_DEPTH = STORE_DEPTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_ready,
  input  req_t       req_data,
  output logic       res_valid,
  input  logic       res_ready,
  output res_t       res_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  level_t     cfg_data
);

  localparam int AW = $clog2(STORE_DEPTH);
  localparam int CW = $clog2(STORE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_COUNT = CW'(STORE_DEPTH);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_FINISH = 4'b0100,
    ST_DONE   = 4'b1000
  } state_t;

  state_t                  state;
  level_t                  node_level;
  level_t                  cur_level;
  logic [CW-1:0]           scope_start;
  logic [CW-1:0]           fill_count;
  logic [CW-1:0]           saved_start [LEVEL_COUNT];
  logic [CW-1:0]           saved_fill  [LEVEL_COUNT];
  level_t                  marked_level;
  logic [CW-1:0]           marked_start;
  logic [CW-1:0]           marked_fill;
  logic [CW-1:0]           ptr;
  logic                    rd_pend;
  logic [1:0]              status;
  logic                    full;
  logic [NUMBER_WIDTH-1:0] item_num;
  logic                    item_mark;

  logic                    wr_en;
  logic [NUMBER_WIDTH-1:0] rd_data;
  logic                    has_room;
  logic                    res_load;

  assign req_ready = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign has_room  = (fill_count < DEPTH_COUNT);
  assign wr_en     = (state == ST_FINISH) && has_room;
  assign res_load  = (state == ST_DONE) && (!res_valid || res_ready);

  // number store
  sdnc_ram #(
    .WIDTH(NUMBER_WIDTH),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(fill_count[AW-1:0]),
    .wr_data(item_num),
    .rd_addr(ptr[AW-1:0]),
    .rd_data(rd_data)
  );

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      node_level <= NODE_LEVEL_RESET;
    end else if (cfg_valid) begin
      node_level <= cfg_data;
    end
  end

  // result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  // sequencer: scope move, scan, append, result
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      cur_level    <= '0;
      scope_start  <= '0;
      fill_count   <= '0;
      marked_level <= '0;
      marked_start <= '0;
      marked_fill  <= '0;
      rd_pend      <= 1'b0;
      for (int k = 0; k < LEVEL_COUNT; k++) begin
        saved_start[k] <= '0;
        saved_fill[k]  <= '0;
      end
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (req_valid) begin
            item_num  <= req_data.number;
            item_mark <= req_data.mark;
            status    <= STATUS_UNIQUE;
            full      <= 1'b0;
            rd_pend   <= 1'b0;
            if (req_data.command == CMD_RESTORE) begin
              cur_level   <= marked_level;
              scope_start <= marked_start;
              fill_count  <= marked_fill;
              state       <= ST_DONE;
            end else begin
              // move the current scope to the requested level
              if (req_data.scope_level < cur_level) begin
                cur_level   <= req_data.scope_level;
                scope_start <= saved_start[req_data.scope_level];
                fill_count  <= saved_fill[req_data.scope_level];
                ptr         <= saved_start[req_data.scope_level];
              end else if (req_data.scope_level > cur_level) begin
                for (int k = 0; k < LEVEL_COUNT; k++) begin
                  if ((LEVEL_WIDTH'(k) >= cur_level) &&
                      (LEVEL_WIDTH'(k) < req_data.scope_level)) begin
                    saved_start[k] <= (LEVEL_WIDTH'(k) == cur_level) ?
                                      scope_start : fill_count;
                    saved_fill[k]  <= fill_count;
                  end
                end
                cur_level   <= req_data.scope_level;
                scope_start <= fill_count;
                ptr         <= fill_count;
              end else begin
                ptr <= scope_start;
              end
              state <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          // one read issued and one compare made per cycle
          if (rd_pend && (rd_data == item_num)) begin
            status <= (cur_level >= node_level) ? STATUS_LOW : STATUS_HIGH;
            state  <= ST_FINISH;
          end else if (ptr < fill_count) begin
            ptr     <= CW'(ptr + 1'b1);
            rd_pend <= 1'b1;
          end else begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          rd_pend <= 1'b0;
          if (item_mark) begin
            marked_level <= cur_level;
            marked_start <= scope_start;
            marked_fill  <= fill_count;
          end
          // append, or flag the store as full
          if (has_room) begin
            fill_count <= CW'(fill_count + 1'b1);
          end else begin
            full <= 1'b1;
          end
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (res_load) begin
            res_data.duplicate_status <= status;
            res_data.store_full       <= full;
            state                     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // fill never passes the store depth
  assert property (@(posedge clk) disable iff (rst) fill_count <= DEPTH_COUNT)
    else $error("fill count beyond store depth");

  // current scope always lies inside the filled part
  assert property (@(posedge clk) disable iff (rst) scope_start <= fill_count)
    else $error("scope start beyond fill count");

  // scan pointer stays within the current scope
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (ptr >= scope_start) && (ptr <= fill_count))
    else $error("scan pointer outside current scope");

  // saved bounds of the zone level are ordered
  assert property (@(posedge clk) disable iff (rst)
    saved_start[0] <= saved_fill[0])
    else $error("saved zone bounds out of order");

  // a result never carries an undefined status code
  assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> (res_data.duplicate_status != 2'd3))
    else $error("undefined duplicate status");

endmodule
